// File: rtl/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared constants, the group record type and the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] RESET_LINE_LENGTH = 8'd72;
  localparam logic [7:0] MIN_LINE_LENGTH   = 8'd4;

  localparam logic [7:0] CHAR_PAD = 8'd61;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_SLASH = 8'd47;

  // One encoded group: four characters, the first in chars[0].
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            last;
  } group_t;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// File: rtl/base64_encoder_line_wrap_top.sv
// ----------------------------------------------------------------------------
// Base64 encoder with line wrapping
// Encodes a byte stream into base64 characters, breaking lines with CR LF.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_*      in         tdata[7:0] in_byte, tlast is_last
//  m_*      out        tdata[7:0] out_char, tuser[0] run_last, tlast stream_last
//  cfg_*    in         wr_data[7:0] line_length, written when wr_en is high
//
// Bytes are taken one per cycle while the group queue has room; every third
// byte, or a last byte, becomes a four-character group in the queue.
// The output side sends one character per cycle while the receiver is ready,
// with a CR LF in front of a character whenever the current line is full.
// Reset is synchronous and clears the held byte count, the queue and the line count.
// A stalled output fills the queue, after which the input stops accepting.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_top
  import b64lw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // in_byte
  input  logic       s_tlast,     // is_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // out_char
  output logic [0:0] m_tuser,     // run_last
  output logic       m_tlast,     // stream_last
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data  // line_length
);

  logic [7:0] line_length;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  group_t     q_wr_data;
  group_t     q_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= RESET_LINE_LENGTH;
    end else if (cfg_wr_en) begin
      line_length <= cfg_wr_data;
    end
  end

  b64lw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  b64lw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .q_valid     (q_valid),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

// File: rtl/b64lw_front.sv
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Gathers input bytes into groups of three and maps each group to four
// characters, padded where the stream ends on a partial group.
// ----------------------------------------------------------------------------
module b64lw_front
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // is_last
  input  logic       q_full,
  output logic       q_push,
  output group_t     q_data
);

  logic [1:0]  held_count;
  logic [15:0] held_bytes;
  logic [1:0]  count;
  logic        accept;
  logic        emit;
  logic [7:0]  b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign count    = held_count + 2'd1;
  assign emit     = (count == 2'd3) || s_tlast;
  assign q_push   = accept && emit;

  always_comb begin
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    b2 = 8'd0;
    case (count)
      2'd1: begin
        b0 = s_tdata;
        b1 = 8'd0;
      end
      2'd2: b1 = s_tdata;
      default: b2 = s_tdata;
    endcase
    q_data.chars[0] = b64_symbol(b0[7:2]);
    q_data.chars[1] = b64_symbol({b0[1:0], b1[7:4]});
    q_data.chars[2] = b64_symbol({b1[3:0], b2[7:6]});
    q_data.chars[3] = b64_symbol(b2[5:0]);
    if (count != 2'd3) begin
      q_data.chars[3] = CHAR_PAD;
      if (count == 2'd1) begin
        q_data.chars[2] = CHAR_PAD;
      end
    end
    q_data.last = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= emit ? 2'd0 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      if (count == 2'd1) begin
        held_bytes <= {s_tdata, 8'd0};
      end else begin
        held_bytes[7:0] <= s_tdata;
      end
    end
  end

endmodule

// File: rtl/b64lw_queue.sv
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// A short first-in first-out queue of encoded groups between the two halves.
// ----------------------------------------------------------------------------
module b64lw_queue
  import b64lw_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t wr_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output group_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  group_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == FULL_CNT);
  assign valid   = (fill != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/b64lw_back.sv
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Sends the characters of each group one per cycle while the output is not stalled,
// putting a CR LF in front of a character whenever the current line is full.
// ----------------------------------------------------------------------------
module b64lw_back
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] line_length,
  input  logic       q_valid,
  input  group_t     q_data,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic [0:0] m_tuser,   // run_last
  output logic       m_tlast    // stream_last
);

  typedef enum logic {
    PH_CHAR,
    PH_LF
  } phase_t;

  phase_t     phase;
  logic [1:0] idx;
  logic [7:0] line_count;
  logic [7:0] limit;
  logic       out_free;
  logic       wrap;
  logic       send_char;

  assign limit     = (line_length < MIN_LINE_LENGTH) ? MIN_LINE_LENGTH : line_length;
  assign out_free  = !m_tvalid || m_tready;
  assign wrap      = (line_count == limit);
  assign send_char = out_free && q_valid && (phase == PH_CHAR) && !wrap;
  assign q_pop     = send_char && (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CHAR;
      idx        <= 2'd0;
      line_count <= 8'd0;
      m_tvalid   <= 1'b0;
      m_tdata    <= 8'd0;
      m_tuser    <= 1'b0;
      m_tlast    <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= q_valid;
      if (q_valid) begin
        if (phase == PH_LF) begin
          m_tdata    <= CHAR_LF;
          m_tuser    <= 1'b0;
          m_tlast    <= 1'b0;
          line_count <= 8'd0;
          phase      <= PH_CHAR;
        end else if (wrap) begin
          m_tdata <= CHAR_CR;
          m_tuser <= 1'b0;
          m_tlast <= 1'b0;
          phase   <= PH_LF;
        end else begin
          m_tdata <= q_data.chars[idx];
          idx     <= idx + 2'd1;
          if (idx == 2'd3) begin
            m_tuser    <= 1'b1;
            m_tlast    <= q_data.last;
            line_count <= q_data.last ? 8'd0 : line_count + 8'd1;
          end else begin
            m_tuser    <= 1'b0;
            m_tlast    <= 1'b0;
            line_count <= line_count + 8'd1;
          end
        end
      end
    end
  end

endmodule

// File: bench/base64_encoder_line_wrap_top_tb.sv
// ----------------------------------------------------------------------------
// Base64 encoder with line wrapping: testbench
// Streams byte runs into the encoder under changing line lengths and idling
// patterns, predicts every character, pad and line break, and compares each
// output item with the oldest prediction.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_top_tb;
  import b64lw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       run_last;
    logic       stream_last;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;     // in_byte
  logic       s_tlast = 1'b0;      // is_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;             // out_char
  logic [0:0] m_tuser;             // run_last
  logic       m_tlast;             // stream_last
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00; // line_length

  base64_encoder_line_wrap_top u_top (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  byte_item_t  pending_bytes[$];
  char_item_t  expected_chars[$];
  byte_item_t  next_byte;
  char_item_t  oldest_char;
  logic        in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  logic [7:0] wrap_length = RESET_LINE_LENGTH;
  logic [7:0] chars_on_line = 8'd0;
  logic [7:0] held_hi = 8'd0;
  logic [7:0] held_lo = 8'd0;
  logic [1:0] held_count = 2'd0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < 100) begin
      $display("tb: mismatch in %s at %0t: got 0x%02h, expected 0x%02h", what, $realtime,
               got, want);
    end
    error_count++;
  endtask

  function automatic void emit_char(input logic [7:0] ch);
    logic [7:0] limit;
    limit = (wrap_length < MIN_LINE_LENGTH) ? MIN_LINE_LENGTH : wrap_length;
    if (chars_on_line == limit) begin
      expected_chars.push_back(char_item_t'{CHAR_CR, 1'b0, 1'b0});
      expected_chars.push_back(char_item_t'{CHAR_LF, 1'b0, 1'b0});
      chars_on_line = 8'd0;
    end
    expected_chars.push_back(char_item_t'{ch, 1'b0, 1'b0});
    chars_on_line = chars_on_line + 8'd1;
  endfunction

  function automatic void encode_byte(input logic [7:0] data, input logic last);
    logic [1:0] count;
    logic [7:0] b0, b1, b2;
    logic [7:0] grp [4];
    count = held_count + 2'd1;
    if (count < 2'd3 && !last) begin
      if (count == 2'd1) begin
        held_hi = data;
      end else begin
        held_lo = data;
      end
      held_count = count;
      return;
    end
    b0 = held_hi;
    b1 = held_lo;
    b2 = 8'd0;
    if (count == 2'd1) begin
      b0 = data;
      b1 = 8'd0;
    end else if (count == 2'd2) begin
      b1 = data;
    end else begin
      b2 = data;
    end
    grp[0] = b64_digits[b0[7:2]];
    grp[1] = b64_digits[{b0[1:0], b1[7:4]}];
    grp[2] = b64_digits[{b1[3:0], b2[7:6]}];
    grp[3] = b64_digits[b2[5:0]];
    if (count < 2'd3) begin
      grp[3] = CHAR_PAD;
      if (count < 2'd2) begin
        grp[2] = CHAR_PAD;
      end
    end
    for (int i = 0; i < 4; i++) begin
      emit_char(grp[i]);
    end
    expected_chars[expected_chars.size() - 1].run_last = 1'b1;
    held_hi = 8'd0;
    held_lo = 8'd0;
    held_count = 2'd0;
    if (last) begin
      expected_chars[expected_chars.size() - 1].stream_last = 1'b1;
      chars_on_line = 8'd0;
    end
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_byte.data;
        s_tlast  <= next_byte.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) begin
        wrap_length = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
        in_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected item", m_tdata, 8'h00);
        end else begin
          oldest_char = expected_chars.pop_front();
          if (m_tdata !== oldest_char.ch) begin
            report_mismatch("out_char", m_tdata, oldest_char.ch);
          end
          if (m_tuser[0] !== oldest_char.run_last) begin
            report_mismatch("run_last", {7'd0, m_tuser[0]}, {7'd0, oldest_char.run_last});
          end
          if (m_tlast !== oldest_char.stream_last) begin
            report_mismatch("stream_last", {7'd0, m_tlast}, {7'd0, oldest_char.stream_last});
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] data, input logic last);
    pending_bytes.push_back(byte_item_t'{data, last});
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(9))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic queue_stream(input int n, input logic with_last);
    for (int i = 0; i < n; i++) begin
      queue_byte(pick_byte(), with_last && (i == n - 1));
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_line_length(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int phase_items;
    int n;
    int sel;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_line_length(MIN_LINE_LENGTH);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);
    wait_quiet();

    write_line_length(8'd2);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h3C, 1'b1);
    wait_quiet();

    write_line_length(RESET_LINE_LENGTH);
    queue_stream(30, 1'b0);
    wait_quiet();
    write_line_length(8'd10);
    queue_stream(40, 1'b1);
    wait_quiet();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_line_length(8'd255);
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
          write_line_length(8'($urandom_range(4, 255)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
          write_line_length(MIN_LINE_LENGTH);
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
          write_line_length(8'($urandom_range(5, 30)));
        end
      endcase
      phase_items = 0;
      while (phase_items < 50) begin
        sel = $urandom_range(9);
        if (sel < 7) begin
          n = $urandom_range(1, 12);
        end else if (sel < 9) begin
          n = $urandom_range(13, 40);
        end else begin
          n = $urandom_range(41, 90);
        end
        queue_stream(n, $urandom_range(9) != 0);
        phase_items += n;
      end
      wait_quiet();
    end

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
